>>> hw/rtl/assert_macros.svh
// Assertion macros used by the integer string parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

>>> hw/rtl/isp_pkg.sv
// Types, constants and the character decoder of the integer string parser.
package isp_pkg;

  typedef logic [63:0] word_t;
  typedef logic [5:0]  digit_t;
  typedef logic [5:0]  base_t;
  typedef logic [1:0]  status_t;
  typedef logic [11:0] offset_t;

  typedef struct packed {
    word_t acc;
    logic  ovf;
  } acc_res_t;

  localparam int OFF_W = 12;
  localparam offset_t OFF_MAX = 12'hFFF;

  localparam word_t S_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam word_t S_MIN = 64'h8000_0000_0000_0000;
  localparam word_t U_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_NOCONV = 2'd1;
  localparam status_t ST_RANGE  = 2'd2;

  localparam logic REG_BASE   = 1'b0;
  localparam logic REG_SIGNED = 1'b1;

  localparam base_t BASE_AUTO = 6'd0;
  localparam base_t BASE_ONE  = 6'd1;
  localparam base_t BASE_OCT  = 6'd8;
  localparam base_t BASE_DEC  = 6'd10;
  localparam base_t BASE_HEX  = 6'd16;
  localparam base_t BASE_TOP  = 6'd36;

  localparam digit_t DIGIT_NONE = 6'd36;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  // Digit value of a character; anything that is not alphanumeric decodes
  // to a value no base accepts.
  function automatic digit_t digit_of(input logic [7:0] c);
    digit_t d;
    d = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 6'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = 6'(c - CH_LA) + BASE_DEC;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = 6'(c - CH_UA) + BASE_DEC;
    end
    return d;
  endfunction

endpackage

>>> hw/rtl/isp_accum.sv
// Multiply-add of one digit into the accumulator, with the range check.
module isp_accum (
  input  isp_pkg::word_t    acc,
  input  isp_pkg::base_t    base,
  input  isp_pkg::digit_t   digit,
  input  logic              signed_mode,
  input  logic              negative,
  output isp_pkg::acc_res_t res
);

  logic [69:0]    prod;
  logic [70:0]    sum;
  isp_pkg::word_t limit;

  assign prod = {6'd0, acc} * {64'd0, base};
  assign sum  = {1'b0, prod} + 71'(digit);

  // A negative signed result may reach one step further than a positive one.
  assign limit = signed_mode ? (negative ? isp_pkg::S_MIN : isp_pkg::S_MAX)
                             : isp_pkg::U_MAX;

  assign res.ovf = sum > {7'd0, limit};
  assign res.acc = sum[63:0];

endmodule

>>> hw/rtl/integer_string_parser.sv
// Top level of the streaming integer string parser.
//
//  Channel   Dir  Signals                       Contents (lowest bit first)
//  s_axis    in   tvalid tready tdata tuser     tdata: character[7:0]; tuser: first
//  m_axis    out  tvalid tready tdata tuser     tdata: value[63:0], end_offset[75:64]
//                                               tuser: status[1:0]
//  cfg       in   cfg_we cfg_index cfg_data     register 0 number_base, 1 signed_mode
//
// One character a cycle unless a waiting result stalls: it is registered on entry,
// and from the entry register it is decoded and folded into the accumulator by one
// 64 by 6 multiply-add. A result is loaded into the output register as the
// character that ends the number leaves the entry register.
// The state update of one character feeds the next, so the multiply-add loop
// sets the clock period.
// A waiting result stalls only the entry stage, and only when a further
// character has arrived behind it; rst clears control state synchronously.
`include "assert_macros.svh"

module integer_string_parser #(
  parameter int MAX_LEN = 4095
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // character[7:0]
  input  logic        s_axis_tuser,   // first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // value[63:0], end_offset[75:64], zeros
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);

  localparam int PosW = $clog2(MAX_LEN + 1);
  localparam int CmpW = (PosW > isp_pkg::OFF_W) ? PosW : isp_pkg::OFF_W;

  localparam logic [2:0] PH_DONE   = 3'd0;
  localparam logic [2:0] PH_LEAD   = 3'd1;
  localparam logic [2:0] PH_SIGNED = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_PREFIX = 3'd4;
  localparam logic [2:0] PH_DIGITS = 3'd5;

  // Configuration registers.
  isp_pkg::base_t cfg_base;
  logic           cfg_signed;

  // Entry stage.
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_first;
  logic       s1_fire;

  // Parser state.
  logic [2:0]      phase, phase_next;
  isp_pkg::word_t  acc, acc_next;
  logic            ovf, ovf_next;
  logic            neg, neg_next;
  isp_pkg::base_t  base, base_next;
  logic            sgn, sgn_next;
  logic [PosW-1:0] position, position_next;
  logic [PosW-1:0] digits_start, digits_start_next;

  // Result register.
  logic             out_valid;
  isp_pkg::word_t   out_value;
  isp_pkg::offset_t out_off;
  isp_pkg::status_t out_status;

  // Values seen by the current character, after a new string resets them.
  logic [2:0]      cur_ph;
  isp_pkg::word_t  cur_acc;
  logic            cur_ovf;
  logic            cur_neg;
  isp_pkg::base_t  cur_base;
  logic            cur_sgn;
  logic [PosW-1:0] cur_pos;
  logic [PosW-1:0] cur_ds;

  isp_pkg::digit_t   dig;
  isp_pkg::base_t    base_eff;
  logic              is_digit;
  logic              bad_base;
  logic [PosW-1:0]   pos_inc;
  isp_pkg::acc_res_t step;
  isp_pkg::word_t    fin_value;
  isp_pkg::status_t  fin_status;

  logic             emit;
  isp_pkg::word_t   emit_value;
  logic [PosW-1:0]  emit_pos;
  isp_pkg::status_t emit_status;
  logic [CmpW-1:0]  emit_wide;
  isp_pkg::offset_t emit_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_base   <= isp_pkg::BASE_DEC;
      cfg_signed <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        isp_pkg::REG_BASE:   cfg_base   <= cfg_data;
        isp_pkg::REG_SIGNED: cfg_signed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The entry stage drains whenever the result register can take a result.
  assign s1_fire       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_char  <= s_axis_tdata;
      s1_first <= s_axis_tuser;
    end
  end

  always_comb begin
    cur_ph   = s1_first ? PH_LEAD : phase;
    cur_acc  = s1_first ? '0 : acc;
    cur_ovf  = s1_first ? 1'b0 : ovf;
    cur_neg  = s1_first ? 1'b0 : neg;
    cur_base = s1_first ? cfg_base : base;
    cur_sgn  = s1_first ? cfg_signed : sgn;
    cur_pos  = s1_first ? '0 : position;
    cur_ds   = s1_first ? '0 : digits_start;
  end

  assign bad_base = s1_first && (cfg_base == isp_pkg::BASE_ONE || cfg_base > isp_pkg::BASE_TOP);
  assign dig      = isp_pkg::digit_of(s1_char);

  // Automatic detection falls back to octal after a leading zero, else decimal.
  assign base_eff = (cur_base != isp_pkg::BASE_AUTO) ? cur_base :
                    (cur_ph == PH_ZERO) ? isp_pkg::BASE_OCT : isp_pkg::BASE_DEC;
  assign is_digit = dig < base_eff;
  assign pos_inc  = (cur_pos < PosW'(MAX_LEN)) ? cur_pos + 1'b1 : cur_pos;

  isp_accum u_accum (
    .acc         (cur_acc),
    .base        (base_eff),
    .digit       (dig),
    .signed_mode (cur_sgn),
    .negative    (cur_neg),
    .res         (step)
  );

  always_comb begin
    if (cur_ovf) begin
      fin_value  = cur_sgn ? (cur_neg ? isp_pkg::S_MIN : isp_pkg::S_MAX) : isp_pkg::U_MAX;
      fin_status = isp_pkg::ST_RANGE;
    end else begin
      fin_value  = cur_neg ? (64'd0 - cur_acc) : cur_acc;
      fin_status = isp_pkg::ST_OK;
    end
  end

  always_comb begin
    phase_next        = cur_ph;
    acc_next          = cur_acc;
    ovf_next          = cur_ovf;
    neg_next          = cur_neg;
    base_next         = cur_base;
    sgn_next          = cur_sgn;
    position_next     = cur_pos;
    digits_start_next = cur_ds;
    emit              = 1'b0;
    emit_value        = '0;
    emit_pos          = '0;
    emit_status       = isp_pkg::ST_NOCONV;

    if (bad_base) begin
      emit       = 1'b1;
      phase_next = PH_DONE;
    end else begin
      unique case (cur_ph) inside
        PH_LEAD, PH_SIGNED: begin
          if (cur_ph == PH_LEAD && (s1_char == isp_pkg::CH_SPACE ||
              s1_char == isp_pkg::CH_TAB || s1_char == isp_pkg::CH_NL)) begin
            position_next = pos_inc;
          end else if (cur_ph == PH_LEAD && (s1_char == isp_pkg::CH_PLUS ||
                       s1_char == isp_pkg::CH_MINUS)) begin
            neg_next      = (s1_char == isp_pkg::CH_MINUS);
            phase_next    = PH_SIGNED;
            position_next = pos_inc;
          end else if ((cur_base == isp_pkg::BASE_AUTO || cur_base == isp_pkg::BASE_HEX) &&
                       s1_char == isp_pkg::CH_ZERO) begin
            digits_start_next = cur_pos;
            phase_next        = PH_ZERO;
            position_next     = pos_inc;
          end else begin
            base_next = base_eff;
            if (!is_digit) begin
              emit       = 1'b1;
              phase_next = PH_DONE;
            end else begin
              digits_start_next = cur_pos;
              phase_next        = PH_DIGITS;
              position_next     = pos_inc;
              if (!cur_ovf) begin
                ovf_next = step.ovf;
                acc_next = step.ovf ? cur_acc : step.acc;
              end
            end
          end
        end
        PH_ZERO, PH_PREFIX, PH_DIGITS: begin
          if (cur_ph == PH_ZERO && (s1_char == isp_pkg::CH_LX || s1_char == isp_pkg::CH_UX)) begin
            base_next         = isp_pkg::BASE_HEX;
            phase_next        = PH_PREFIX;
            position_next     = pos_inc;
            digits_start_next = pos_inc;
          end else if (cur_ph == PH_PREFIX && !is_digit) begin
            // A bare hex prefix converts the zero and stops at the x.
            emit        = 1'b1;
            emit_status = isp_pkg::ST_OK;
            emit_pos    = (cur_ds != '0) ? cur_ds - 1'b1 : '0;
            phase_next  = PH_DONE;
          end else begin
            base_next = base_eff;
            if (!is_digit) begin
              emit        = 1'b1;
              emit_value  = fin_value;
              emit_status = fin_status;
              emit_pos    = cur_pos;
              phase_next  = PH_DONE;
            end else begin
              phase_next    = PH_DIGITS;
              position_next = pos_inc;
              if (!cur_ovf) begin
                ovf_next = step.ovf;
                acc_next = step.ovf ? cur_acc : step.acc;
              end
            end
          end
        end
        default: phase_next = PH_DONE;
      endcase
    end
  end

  assign emit_wide = CmpW'(emit_pos);
  assign emit_off  = (emit_wide > CmpW'(isp_pkg::OFF_MAX)) ? isp_pkg::OFF_MAX
                                                            : emit_wide[isp_pkg::OFF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DONE;
      acc          <= '0;
      ovf          <= 1'b0;
      neg          <= 1'b0;
      base         <= isp_pkg::BASE_DEC;
      sgn          <= 1'b1;
      position     <= '0;
      digits_start <= '0;
    end else if (s1_fire) begin
      phase        <= phase_next;
      acc          <= acc_next;
      ovf          <= ovf_next;
      neg          <= neg_next;
      base         <= base_next;
      sgn          <= sgn_next;
      position     <= position_next;
      digits_start <= digits_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_value  <= emit_value;
      out_off    <= emit_off;
      out_status <= emit_status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_off, out_value};
  assign m_axis_tuser  = out_status;

  `ASSERT_NEVER(a_pos_range, clk, rst, position > PosW'(MAX_LEN))
  `ASSERT_PROP(a_stall_cause, clk, rst, !s_axis_tready |-> out_valid && !m_axis_tready)
  `ASSERT_PROP(a_emit_loads, clk, rst, s1_fire && emit |=> out_valid)
  `ASSERT_PROP(a_noconv_zero, clk, rst, out_valid && out_status == isp_pkg::ST_NOCONV |-> out_value == '0 && out_off == '0)
  `ASSERT_PROP(a_range_sat, clk, rst, out_valid && out_status == isp_pkg::ST_RANGE |-> out_value == isp_pkg::S_MAX || out_value == isp_pkg::S_MIN || out_value == isp_pkg::U_MAX)

endmodule

>>> tb/tb_top.sv
// Self-checking testbench of the streaming integer string parser.
module tb_top;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_BLANKS, SCAN_SIGNED, SCAN_ZERO, SCAN_PREFIX, SCAN_DIGITS
  } scan_t;

  typedef enum logic [1:0] {
    IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    isp_pkg::word_t   value;
    isp_pkg::offset_t end_offset;
    isp_pkg::status_t status;
  } number_t;

  localparam int unsigned SCAN_LIMIT = 4095;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_CHARS = 104;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // character[7:0]
  logic        s_axis_tuser = 1'b0; // first
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // value[63:0], end_offset[75:64], zeros
  logic [1:0]  m_axis_tuser;        // status[1:0]
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [5:0]  cfg_data = '0;

  // Configuration as last written, and the parser state of the current string.
  isp_pkg::base_t base_reg = isp_pkg::BASE_DEC;
  logic           signed_reg = 1'b1;
  scan_t          scan = SCAN_IDLE;
  isp_pkg::word_t acc = '0;
  logic           acc_ovf = 1'b0;
  logic           acc_neg = 1'b0;
  logic           signed_rules = 1'b1;
  isp_pkg::base_t radix = isp_pkg::BASE_DEC;
  int unsigned    pos = 0;
  int unsigned    digits_at = 0;

  number_t     expected_numbers[$];
  int          mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  integer_string_parser dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned char_value(input logic [7:0] c);
    if (c >= isp_pkg::CH_ZERO && c <= isp_pkg::CH_NINE) return c - isp_pkg::CH_ZERO;
    if (c >= isp_pkg::CH_LA && c <= isp_pkg::CH_LZ) return c - isp_pkg::CH_LA + 10;
    if (c >= isp_pkg::CH_UA && c <= isp_pkg::CH_UZ) return c - isp_pkg::CH_UA + 10;
    return 36;
  endfunction

  function automatic void bump_pos();
    if (pos < SCAN_LIMIT) pos++;
  endfunction

  function automatic bit conclude(output number_t r, input isp_pkg::word_t v,
                                  input int unsigned off, input isp_pkg::status_t st);
    r.value = v;
    r.end_offset = (off > 4095) ? isp_pkg::OFF_MAX : isp_pkg::offset_t'(off);
    r.status = st;
    scan = SCAN_IDLE;
    return 1'b1;
  endfunction

  // Multiply-add with a clamp check against the limit of the current mode and sign.
  function automatic void fold_digit(input int unsigned d);
    isp_pkg::word_t b;
    isp_pkg::word_t dw;
    isp_pkg::word_t ceiling;
    b = (radix == isp_pkg::BASE_AUTO) ? isp_pkg::word_t'(isp_pkg::BASE_DEC)
                                      : isp_pkg::word_t'(radix);
    dw = isp_pkg::word_t'(d);
    if (acc_ovf) return;
    if (signed_rules) ceiling = acc_neg ? isp_pkg::S_MIN : isp_pkg::S_MAX;
    else ceiling = isp_pkg::U_MAX;
    if (acc > (ceiling - dw) / b) acc_ovf = 1'b1;
    else acc = acc * b + dw;
  endfunction

  function automatic bit digit_step(input logic [7:0] c, output number_t r);
    if (char_value(c) >= radix) begin
      if (acc_ovf) begin
        return conclude(r, signed_rules ? (acc_neg ? isp_pkg::S_MIN : isp_pkg::S_MAX)
                                        : isp_pkg::U_MAX, pos, isp_pkg::ST_RANGE);
      end
      return conclude(r, acc_neg ? -acc : acc, pos, isp_pkg::ST_OK);
    end
    fold_digit(char_value(c));
    bump_pos();
    return 1'b0;
  endfunction

  // The character where the number proper begins, after blanks and sign.
  function automatic bit begin_number(input logic [7:0] c, output number_t r);
    if ((radix == isp_pkg::BASE_AUTO || radix == isp_pkg::BASE_HEX) &&
        c == isp_pkg::CH_ZERO) begin
      digits_at = pos;
      scan = SCAN_ZERO;
      bump_pos();
      return 1'b0;
    end
    if (radix == isp_pkg::BASE_AUTO) radix = isp_pkg::BASE_DEC;
    if (char_value(c) >= radix) return conclude(r, '0, 0, isp_pkg::ST_NOCONV);
    digits_at = pos;
    scan = SCAN_DIGITS;
    fold_digit(char_value(c));
    bump_pos();
    return 1'b0;
  endfunction

  function automatic bit parse_char(input logic [7:0] c, input logic first,
                                    output number_t r);
    if (first) begin
      pos = 0;
      acc = '0;
      acc_ovf = 1'b0;
      acc_neg = 1'b0;
      digits_at = 0;
      radix = base_reg;
      signed_rules = signed_reg;
      if (radix == isp_pkg::BASE_ONE || radix > isp_pkg::BASE_TOP) begin
        return conclude(r, '0, 0, isp_pkg::ST_NOCONV);
      end
      scan = SCAN_BLANKS;
    end
    case (scan)
      SCAN_BLANKS: begin
        if (c == isp_pkg::CH_SPACE || c == isp_pkg::CH_TAB || c == isp_pkg::CH_NL) begin
          bump_pos();
          return 1'b0;
        end
        if (c == isp_pkg::CH_MINUS || c == isp_pkg::CH_PLUS) begin
          acc_neg = (c == isp_pkg::CH_MINUS);
          scan = SCAN_SIGNED;
          bump_pos();
          return 1'b0;
        end
        return begin_number(c, r);
      end
      SCAN_SIGNED: return begin_number(c, r);
      SCAN_ZERO: begin
        if (c == isp_pkg::CH_LX || c == isp_pkg::CH_UX) begin
          radix = isp_pkg::BASE_HEX;
          scan = SCAN_PREFIX;
          bump_pos();
          digits_at = pos;
          return 1'b0;
        end
        if (radix == isp_pkg::BASE_AUTO) radix = isp_pkg::BASE_OCT;
        scan = SCAN_DIGITS;
        return digit_step(c, r);
      end
      SCAN_PREFIX: begin
        if (char_value(c) < 16) begin
          scan = SCAN_DIGITS;
          return digit_step(c, r);
        end
        // A bare prefix ends at the x itself.
        return conclude(r, '0, (digits_at > 0) ? digits_at - 1 : 0, isp_pkg::ST_OK);
      end
      SCAN_DIGITS: return digit_step(c, r);
      default: return 1'b0;
    endcase
  endfunction

  function automatic void set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 56;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct = 56;
      end
      default: begin
        send_idle_pct = 35;
        stall_pct = 35;
      end
    endcase
  endfunction

  // Each accepted request is predicted at the edge where it is taken.
  task automatic send_char(input logic [7:0] c, input logic first);
    number_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tuser <= first;
    do @(posedge clk); while (!s_axis_tready);
    if (parse_char(c, first, r)) expected_numbers.push_back(r);
  endtask

  task automatic send_bytes(input logic [7:0] text[$]);
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == 0);
  endtask

  task automatic send_text(input string s, input bit nul_end);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    if (nul_end) text.push_back(8'h00);
    send_bytes(text);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_numbers.size() != 0) @(posedge clk);
    // Characters that give no result may still be in the pipeline.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input isp_pkg::base_t nb, input logic sm);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= isp_pkg::REG_BASE;
    cfg_data <= nb;
    @(negedge clk);
    cfg_index <= isp_pkg::REG_SIGNED;
    cfg_data <= {5'($urandom), sm};
    @(negedge clk);
    cfg_we <= 1'b0;
    base_reg = nb;
    signed_reg = sm;
  endtask

  // A well-formed number for the current base with random content, sometimes
  // left unfinished or followed by characters that are to be ignored.
  function automatic void build_number(output logic [7:0] text[$]);
    int unsigned eb;
    int unsigned n;
    int unsigned len;
    int unsigned d;
    logic [127:0] reach;
    logic [7:0] c;
    text.delete();
    repeat ($urandom_range(0, 1) * $urandom_range(0, 3)) begin
      case ($urandom_range(0, 2))
        0: text.push_back(isp_pkg::CH_SPACE);
        1: text.push_back(isp_pkg::CH_TAB);
        default: text.push_back(isp_pkg::CH_NL);
      endcase
    end
    case ($urandom_range(0, 2))
      1: text.push_back(isp_pkg::CH_PLUS);
      2: text.push_back(isp_pkg::CH_MINUS);
      default: ;
    endcase
    eb = base_reg;
    if (base_reg == isp_pkg::BASE_AUTO) begin
      case ($urandom_range(0, 2))
        0: begin
          text.push_back(isp_pkg::CH_ZERO);
          text.push_back($urandom_range(0, 1) ? isp_pkg::CH_LX : isp_pkg::CH_UX);
          eb = isp_pkg::BASE_HEX;
        end
        1: begin
          text.push_back(isp_pkg::CH_ZERO);
          eb = isp_pkg::BASE_OCT;
        end
        default: eb = isp_pkg::BASE_DEC;
      endcase
    end else if (base_reg == isp_pkg::BASE_HEX && $urandom_range(0, 1)) begin
      text.push_back(isp_pkg::CH_ZERO);
      text.push_back($urandom_range(0, 1) ? isp_pkg::CH_LX : isp_pkg::CH_UX);
    end
    reach = 1;
    n = 0;
    while (reach[127:64] == 0) begin
      reach = reach * eb;
      n++;
    end
    case ($urandom_range(0, 9)) inside
      [0:2]: len = $urandom_range(0, 4);
      [3:7]: len = $urandom_range(n - 2, n + 1);
      default: len = $urandom_range(0, n);
    endcase
    for (int i = 0; i < len; i++) begin
      d = $urandom_range((i == 0 && base_reg == isp_pkg::BASE_AUTO &&
                          eb == isp_pkg::BASE_DEC) ? 1 : 0, eb - 1);
      c = (d < 10) ? 8'(isp_pkg::CH_ZERO + d)
                   : 8'(($urandom_range(0, 1) ? isp_pkg::CH_LA : isp_pkg::CH_UA) + d - 10);
      text.push_back(c);
    end
    case ($urandom_range(0, 9)) inside
      0: ;
      [1:5]: text.push_back(8'h00);
      default: begin
        do c = 8'($urandom_range(0, 255)); while (char_value(c) < eb);
        text.push_back(c);
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic test_reset_defaults();
    set_idling(IDLE_NONE);
    send_text(" \t\n+42,", 1'b0);
    send_text("-17", 1'b1);
  endtask

  task automatic test_special_cases();
    set_idling(IDLE_BOTH);
    write_config(isp_pkg::BASE_AUTO, 1'b1);
    send_text("0x1F ", 1'b0);
    send_text("0x", 1'b1);
    send_text("017 ", 1'b0);
    send_text("08", 1'b1);
    send_text("-z", 1'b1);
    send_text("", 1'b1);
    write_config(isp_pkg::BASE_HEX, 1'b0);
    send_text("0XfF!", 1'b0);
    send_text("-1", 1'b1);
    write_config(isp_pkg::BASE_TOP, 1'b1);
    send_text("zZ", 1'b1);
    write_config(6'd2, 1'b0);
    send_text("102", 1'b0);
    write_config(isp_pkg::BASE_ONE, 1'b1);
    send_text("5", 1'b1);
    write_config(6'd63, 1'b1);
    send_text("7", 1'b1);
    write_config(6'd37, 1'b0);
    send_text("1", 1'b0);
    write_config(isp_pkg::BASE_DEC, 1'b1);
    // An unfinished string is dropped when the next one starts.
    send_text("12", 1'b0);
    send_text("7", 1'b1);
    send_text("5 678", 1'b1);
  endtask

  task automatic test_limits();
    set_idling(IDLE_RECEIVER);
    write_config(isp_pkg::BASE_DEC, 1'b1);
    send_text("9223372036854775807", 1'b1);
    send_text("9223372036854775808", 1'b1);
    send_text("-9223372036854775808", 1'b1);
    send_text("-9223372036854775809", 1'b1);
    send_text("99999999999999999999999", 1'b1);
    write_config(isp_pkg::BASE_DEC, 1'b0);
    send_text("18446744073709551615", 1'b1);
    send_text("18446744073709551616", 1'b1);
    send_text("-18446744073709551615", 1'b1);
    send_text("-18446744073709551616", 1'b1);
    write_config(isp_pkg::BASE_HEX, 1'b1);
    send_text("0x8000000000000000", 1'b1);
    send_text("-0x8000000000000000", 1'b1);
  endtask

  task automatic test_random();
    logic [7:0] text[$];
    isp_pkg::base_t bases[14] = '{isp_pkg::BASE_AUTO, isp_pkg::BASE_DEC, isp_pkg::BASE_HEX,
                                  isp_pkg::BASE_TOP, 6'd2, isp_pkg::BASE_OCT,
                                  isp_pkg::BASE_AUTO, isp_pkg::BASE_TOP, 6'd2,
                                  isp_pkg::BASE_DEC, isp_pkg::BASE_HEX, isp_pkg::BASE_OCT,
                                  isp_pkg::BASE_DEC, isp_pkg::BASE_DEC};
    logic modes[14] = '{0, 0, 1, 1, 0, 1, 1, 0, 1, 1, 0, 0, 0, 1};
    int unsigned used;
    for (int p = 0; p < 14; p++) begin
      if (p < 12) write_config(bases[p], modes[p]);
      else write_config(isp_pkg::base_t'($urandom_range(2, 36)), modes[p]);
      set_idling(idle_mode_t'(p % 4));
      used = 0;
      while (used < PHASE_CHARS) begin
        if ($urandom_range(0, 9) == 0) begin
          text.delete();
          repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
        end else begin
          build_number(text);
        end
        send_bytes(text);
        used += text.size();
      end
    end
  endtask

  // The position counter reaches its limit within the digits of this string.
  task automatic test_long_string();
    logic [7:0] text[$];
    set_idling(IDLE_NONE);
    write_config(isp_pkg::BASE_DEC, 1'b1);
    repeat (4093) text.push_back(isp_pkg::CH_SPACE);
    text.push_back(isp_pkg::CH_MINUS);
    text.push_back(8'(isp_pkg::CH_ZERO + 4));
    text.push_back(8'(isp_pkg::CH_ZERO + 2));
    text.push_back(8'h00);
    send_bytes(text);
  endtask

  always @(negedge clk) m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    number_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_numbers.size() == 0) begin
        $error("unexpected result: value %h end_offset %0d status %0d",
               m_axis_tdata[63:0], m_axis_tdata[75:64], m_axis_tuser);
        mismatch_count++;
      end else begin
        want = expected_numbers.pop_front();
        if (m_axis_tdata[63:0] !== want.value) begin
          $error("value: expected %h, got %h", want.value, m_axis_tdata[63:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[75:64] !== want.end_offset) begin
          $error("end_offset: expected %0d, got %0d", want.end_offset, m_axis_tdata[75:64]);
          mismatch_count++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tdata[79:76] !== 4'b0) begin
          $error("tdata padding: expected 0, got %h", m_axis_tdata[79:76]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_special_cases();
    test_limits();
    test_random();
    test_long_string();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASS integer_string_parser");
    end else begin
      $display("FAIL integer_string_parser");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL integer_string_parser");
    $finish;
  end

endmodule

>>> integer_string_parser.f
+incdir+hw/rtl
hw/rtl/isp_pkg.sv
hw/rtl/isp_accum.sv
hw/rtl/integer_string_parser.sv
tb/tb_top.sv
